### rtl/slt_pkg.sv
// Shared types and constants for the shell line tokenizer.
// Used by the front, queue, back and top-level modules; depends on nothing.
package slt_pkg;

    localparam int MAX_RES = 7;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [9:0] COUNT_MAX = 10'd1023;

    localparam int FLAG_REDIRECT   = 0;
    localparam int FLAG_PIPELINE   = 1;
    localparam int FLAG_AND        = 2;
    localparam int FLAG_BACKGROUND = 3;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_BYTE,
        KIND_END,
        KIND_SUMMARY
    } kind_t;

    typedef enum logic [1:0] {
        CLS_WORD,
        CLS_QUOTE,
        CLS_OP,
        CLS_UNUSED
    } cls_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        cls_t       cls;
    } res_t;

    // One entry holds every result caused by one input byte.
    typedef struct packed {
        logic [2:0]              n_res;
        res_t [MAX_RES-1:0]      res;
        logic [3:0]              flags;
        logic [9:0]              count;
        logic                    unclosed;
    } entry_t;

endpackage

### rtl/slt_front.sv
// Front end of the shell line tokenizer: accepts bytes, holds the lexer state
// and turns each byte into a queue entry of results. Depends on slt_pkg.
module slt_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,     // ch
    input  logic              q_full,
    output logic              q_push,
    output slt_pkg::entry_t   q_entry
);

    typedef enum logic [1:0] {
        MODE_BETWEEN,
        MODE_WORD,
        MODE_QUOTE,
        MODE_UNUSED
    } mode_t;

    typedef enum logic [2:0] {
        P_NONE,
        P_GT,
        P_LT,
        P_TWO,
        P_TWO_GT,
        P_AMP,
        P_AMP_GT
    } pend_t;

    typedef struct packed {
        logic [2:0]                          n;
        slt_pkg::res_t [slt_pkg::MAX_RES-1:0] res;
    } fill_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_BAR    = 8'h7C;

    mode_t      mode_reg,  mode_next;
    pend_t      pend_reg,  pend_next;
    logic       bs_reg,    bs_next;
    logic [3:0] flags_reg, flags_next;
    logic [9:0] cnt_reg,   cnt_next;
    fill_t      fill;
    logic       line_end;
    logic       unclosed;
    logic [3:0] sum_flags;
    logic [9:0] sum_cnt;
    logic       accept;

    function automatic fill_t put(fill_t f, slt_pkg::kind_t k, logic [7:0] d,
                                  slt_pkg::cls_t cl);
        fill_t r;
        r = f;
        r.res[f.n].kind = k;
        r.res[f.n].data = d;
        r.res[f.n].cls  = cl;
        r.n             = f.n + 3'd1;
        return r;
    endfunction

    function automatic fill_t emit_op(fill_t f, logic [7:0] b0, logic [7:0] b1,
                                      logic [7:0] b2, logic [1:0] len);
        fill_t r;
        r = put(f, slt_pkg::KIND_START, 8'd0, slt_pkg::CLS_OP);
        r = put(r, slt_pkg::KIND_BYTE, b0, slt_pkg::CLS_OP);
        if (len > 2'd1)
        begin
            r = put(r, slt_pkg::KIND_BYTE, b1, slt_pkg::CLS_OP);
        end
        if (len > 2'd2)
        begin
            r = put(r, slt_pkg::KIND_BYTE, b2, slt_pkg::CLS_OP);
        end
        r = put(r, slt_pkg::KIND_END, 8'd0, slt_pkg::CLS_OP);
        return r;
    endfunction

    function automatic logic [9:0] sat_inc(logic [9:0] v);
        return (v < slt_pkg::COUNT_MAX) ? v + 10'd1 : v;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic ends_word(logic [7:0] c);
        return is_space(c) || c == CH_LT || c == CH_GT || c == CH_AMP
            || c == CH_BAR || c == CH_QUOTE;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        pend_t p;
        logic  done;
        fill       = '0;
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        bs_next    = bs_reg;
        flags_next = flags_reg;
        cnt_next   = cnt_reg;
        line_end   = 1'b0;
        unclosed   = 1'b0;
        done       = 1'b0;
        p          = pend_reg;
        if (mode_reg == MODE_QUOTE)
        begin
            if (s_tdata == CH_NUL)
            begin
                line_end = 1'b1;
                unclosed = 1'b1;
            end
            else if (s_tdata == CH_QUOTE && !bs_reg)
            begin
                fill      = put(fill, slt_pkg::KIND_END, 8'd0, slt_pkg::CLS_QUOTE);
                cnt_next  = sat_inc(cnt_next);
                mode_next = MODE_BETWEEN;
                bs_next   = 1'b0;
            end
            else
            begin
                fill    = put(fill, slt_pkg::KIND_BYTE, s_tdata, slt_pkg::CLS_QUOTE);
                bs_next = (s_tdata == CH_BSLASH);
            end
        end
        else
        begin
            pend_next = P_NONE;
            unique case (p)
                P_NONE:
                begin
                end
                P_GT:
                begin
                    done = (s_tdata == CH_GT);
                    fill = emit_op(fill, CH_GT, CH_GT, 8'd0, done ? 2'd2 : 2'd1);
                    cnt_next = sat_inc(cnt_next);
                    flags_next[slt_pkg::FLAG_REDIRECT] = 1'b1;
                end
                P_LT:
                begin
                    done = (s_tdata == CH_LT);
                    fill = emit_op(fill, CH_LT, CH_LT, 8'd0, done ? 2'd2 : 2'd1);
                    cnt_next = sat_inc(cnt_next);
                    flags_next[slt_pkg::FLAG_REDIRECT] = 1'b1;
                end
                P_TWO:
                begin
                    if (s_tdata == CH_GT)
                    begin
                        pend_next = P_TWO_GT;
                        done      = 1'b1;
                    end
                    else
                    begin
                        fill = put(fill, slt_pkg::KIND_START, 8'd0, slt_pkg::CLS_WORD);
                        fill = put(fill, slt_pkg::KIND_BYTE, CH_TWO, slt_pkg::CLS_WORD);
                        mode_next = MODE_WORD;
                    end
                end
                P_TWO_GT:
                begin
                    done = (s_tdata == CH_GT);
                    fill = emit_op(fill, CH_TWO, CH_GT, CH_GT, done ? 2'd3 : 2'd2);
                    cnt_next = sat_inc(cnt_next);
                    flags_next[slt_pkg::FLAG_REDIRECT] = 1'b1;
                end
                P_AMP:
                begin
                    if (s_tdata == CH_GT)
                    begin
                        pend_next = P_AMP_GT;
                        done      = 1'b1;
                    end
                    else if (s_tdata == CH_AMP)
                    begin
                        fill = emit_op(fill, CH_AMP, CH_AMP, 8'd0, 2'd2);
                        cnt_next = sat_inc(cnt_next);
                        flags_next[slt_pkg::FLAG_AND] = 1'b1;
                        done = 1'b1;
                    end
                    else
                    begin
                        flags_next[slt_pkg::FLAG_BACKGROUND] = 1'b1;
                    end
                end
                P_AMP_GT:
                begin
                    done = (s_tdata == CH_GT);
                    fill = emit_op(fill, CH_AMP, CH_GT, CH_GT, done ? 2'd3 : 2'd2);
                    cnt_next = sat_inc(cnt_next);
                    flags_next[slt_pkg::FLAG_REDIRECT] = 1'b1;
                end
                default:
                begin
                end
            endcase

            if (!done && mode_next == MODE_WORD)
            begin
                if (s_tdata == CH_NUL || ends_word(s_tdata))
                begin
                    fill      = put(fill, slt_pkg::KIND_END, 8'd0, slt_pkg::CLS_WORD);
                    cnt_next  = sat_inc(cnt_next);
                    mode_next = MODE_BETWEEN;
                end
                else
                begin
                    fill = put(fill, slt_pkg::KIND_BYTE, s_tdata, slt_pkg::CLS_WORD);
                    done = 1'b1;
                end
            end

            if (!done && s_tdata != CH_NUL && !is_space(s_tdata))
            begin
                unique case (s_tdata)
                    CH_GT:    pend_next = P_GT;
                    CH_LT:    pend_next = P_LT;
                    CH_TWO:   pend_next = P_TWO;
                    CH_AMP:   pend_next = P_AMP;
                    CH_BAR:
                    begin
                        fill = emit_op(fill, CH_BAR, 8'd0, 8'd0, 2'd1);
                        cnt_next = sat_inc(cnt_next);
                        flags_next[slt_pkg::FLAG_PIPELINE] = 1'b1;
                    end
                    CH_QUOTE:
                    begin
                        fill = put(fill, slt_pkg::KIND_START, 8'd0, slt_pkg::CLS_QUOTE);
                        mode_next = MODE_QUOTE;
                        bs_next   = 1'b0;
                    end
                    default:
                    begin
                        fill = put(fill, slt_pkg::KIND_START, 8'd0, slt_pkg::CLS_WORD);
                        fill = put(fill, slt_pkg::KIND_BYTE, s_tdata, slt_pkg::CLS_WORD);
                        mode_next = MODE_WORD;
                    end
                endcase
            end

            line_end = (s_tdata == CH_NUL);
        end

        sum_flags = flags_next;
        sum_cnt   = cnt_next;
        if (line_end)
        begin
            fill       = put(fill, slt_pkg::KIND_SUMMARY, 8'd0, slt_pkg::CLS_WORD);
            mode_next  = MODE_BETWEEN;
            pend_next  = P_NONE;
            bs_next    = 1'b0;
            flags_next = 4'd0;
            cnt_next   = 10'd0;
        end
    end

    assign q_push           = accept && (fill.n != 3'd0);
    assign q_entry.n_res    = fill.n;
    assign q_entry.res      = fill.res;
    assign q_entry.flags    = sum_flags;
    assign q_entry.count    = sum_cnt;
    assign q_entry.unclosed = unclosed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BETWEEN;
            pend_reg  <= P_NONE;
            bs_reg    <= 1'b0;
            flags_reg <= 4'd0;
            cnt_reg   <= 10'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            bs_reg    <= bs_next;
            flags_reg <= flags_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

### rtl/slt_queue.sv
// Short queue of result entries between the tokenizer front and back ends.
// Depends on slt_pkg for the entry type and depth.
module slt_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  slt_pkg::entry_t   push_entry,
    output logic              full,
    output logic              head_valid,
    output slt_pkg::entry_t   head_entry,
    input  logic              pop
);

    slt_pkg::entry_t               mem_reg [slt_pkg::QDEPTH];
    logic [slt_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [slt_pkg::QCNT_W-1:0]    cnt_reg;
    logic                          do_pop;

    function automatic logic [slt_pkg::QPTR_W-1:0] ptr_inc(
        logic [slt_pkg::QPTR_W-1:0] p);
        return (p == slt_pkg::QPTR_W'(slt_pkg::QDEPTH - 1))
            ? '0 : p + slt_pkg::QPTR_W'(1);
    endfunction

    assign full       = (cnt_reg == slt_pkg::QCNT_W'(slt_pkg::QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if ((push && !full) && !do_pop)
            begin
                cnt_reg <= cnt_reg + slt_pkg::QCNT_W'(1);
            end
            else if (!(push && !full) && do_pop)
            begin
                cnt_reg <= cnt_reg - slt_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/slt_back.sv
// Back end of the shell line tokenizer (depends on slt_pkg): walks the head
// entry's results into a registered output stage, one beat per ready cycle.
module slt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  slt_pkg::entry_t   head_entry,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,
    output logic [3:0]        m_tuser,
    output logic              m_tlast
);

    logic [2:0]     idx_reg, idx_next;
    logic           valid_reg;
    logic [23:0]    tdata_reg, tdata_next;
    logic [3:0]     tuser_reg;
    logic           tlast_reg, tlast_next;
    logic           load;
    slt_pkg::res_t  cur;

    assign load = head_valid && (!valid_reg || m_tready);
    assign cur  = head_entry.res[idx_reg];

    always_comb
    begin
        tlast_next = (idx_reg == head_entry.n_res - 3'd1);
        idx_next   = tlast_next ? 3'd0 : idx_reg + 3'd1;
        if (cur.kind == slt_pkg::KIND_SUMMARY)
        begin
            tdata_next = {1'b0, head_entry.unclosed, head_entry.count,
                          head_entry.flags, cur.data};
        end
        else
        begin
            tdata_next = {16'd0, cur.data};
        end
    end

    assign pop = load && tlast_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            idx_reg   <= idx_next;
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tdata_reg <= tdata_next;
            tuser_reg <= {cur.cls, cur.kind};
            tlast_reg <= tlast_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

### rtl/shell_line_tokenizer_top.sv
// Top level of the shell line tokenizer: front end, entry queue, back end.
// Depends on slt_pkg, slt_front, slt_queue and slt_back.
//
// Command-line bytes enter on the s_ stream, one byte per beat; byte 0 ends
// the line. Results leave on the m_ stream: kind and token class in tuser,
// the token byte and the line summary fields in tdata, and tlast on the final
// result caused by each input byte.
// The front takes a byte in every cycle while the two-entry queue has room
// and turns it into zero to seven results in that same cycle. The back sends
// one result per cycle while the receiver is ready, so a byte's results hold
// the output in turn; bytes without results (whitespace, a held operator
// prefix) never enter the queue. The first result of a byte is written to
// the queue and then to the registered output stage before it is shown.
// Reset clears the lexer state, the queue and the output stage; no clearing
// pass follows. When the receiver stalls, the output beat holds, the queue
// fills, and s_tready drops once both entries are taken.
module shell_line_tokenizer_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] data, [8] redirect, [9] pipeline,
                                   // [10] and_seen, [11] background,
                                   // [21:12] token_count, [22] unclosed_quote,
                                   // [23] zero
    output logic [3:0]  m_tuser,   // [1:0] kind, [3:2] token_class
    output logic        m_tlast
);

    logic            q_push;
    slt_pkg::entry_t q_entry;
    logic            q_full;
    logic            head_valid;
    slt_pkg::entry_t head_entry;
    logic            q_pop;

    slt_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry)
    );

    slt_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop)
    );

    slt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

`ifndef ASSERT_OFF
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] == slt_pkg::KIND_SUMMARY |-> m_tlast)
        else $error("line summary beat is not marked last");

    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != slt_pkg::KIND_SUMMARY |-> m_tdata[23:8] == 16'd0)
        else $error("summary fields set on a token beat");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1:0] != slt_pkg::KIND_BYTE |-> m_tdata[7:0] == 8'd0)
        else $error("data set on a beat that carries no token byte");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !q_push && !s_tready)
        else $error("entry pushed into a full queue");
`endif

endmodule
